// ===== design/tsb_pkg.sv =====
// shared types and constants of the trend signal backtester
`default_nettype none

package tsb_pkg;

    // fixed field widths of a result word
    localparam int SIGNAL_W       = 2;
    localparam int ACTION_W       = 2;
    localparam int TRADE_RESULT_W = 25;
    localparam int WINDOW_TOTAL_W = 29;
    localparam int SLOPE_W        = 48;
    localparam int BALANCE_W      = 48;
    localparam int COUNT_W        = 32;
    localparam int PROFIT_W       = 47;
    localparam int LOSS_W         = 48;

    // result word on the master side, padded to whole bytes
    localparam int RESULT_BITS   = SIGNAL_W + ACTION_W + TRADE_RESULT_W + WINDOW_TOTAL_W
                                 + SLOPE_W + BALANCE_W + 3 * COUNT_W + PROFIT_W + LOSS_W;
    localparam int RESULT_DATA_W = ((RESULT_BITS + 7) / 8) * 8;
    localparam int RESULT_PAD_W  = RESULT_DATA_W - RESULT_BITS;

    // configuration port
    localparam int WINLEN_W    = 6;
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_BALANCE = 1'b1;

    localparam int WINDOW_RESET = 5;
    localparam logic [BALANCE_W-1:0] BALANCE_RESET = 48'd1000000;

    // saturation limits for the balance and profit/loss totals
    localparam int SAT_W = 49;
    localparam logic signed [SAT_W-1:0] SAT_HI = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_LO = 49'sh1_8000_0000_0000;

    typedef enum logic [SIGNAL_W-1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_FINAL = 2'd3
    } action_t;

    typedef struct packed {
        logic signed [LOSS_W-1:0]         loss_sum;
        logic [PROFIT_W-1:0]              profit_sum;
        logic [COUNT_W-1:0]               losses_done;
        logic [COUNT_W-1:0]               wins_done;
        logic [COUNT_W-1:0]               trades_done;
        logic signed [BALANCE_W-1:0]      balance_now;
        logic signed [SLOPE_W-1:0]        slope_numerator;
        logic [WINDOW_TOTAL_W-1:0]        window_total;
        logic signed [TRADE_RESULT_W-1:0] trade_result;
        action_t                          trade_action;
        signal_t                          trade_signal;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tsb_window.sv =====
// price window: ring buffer, fill count and incremental plain and weighted sums
`default_nettype none

module tsb_window #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24,
    localparam int WIN_W = $clog2(WINDOW_MAX + 1),
    localparam int PTR_W = $clog2(WINDOW_MAX),
    localparam int SX_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2,
    localparam int SX_W = $clog2(SX_MAX + 1),
    localparam int SUM_W = PRICE_BITS + WIN_W,
    localparam int SXY_W = PRICE_BITS + SX_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          win_load,
    input  logic [tsb_pkg::WINLEN_W-1:0]  win_value,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PRICE_BITS-1:0]         in_price,
    input  logic                          in_last,
    output logic                          a_valid,
    input  logic                          a_ready,
    output logic [PRICE_BITS-1:0]         a_price,
    output logic                          a_last,
    output logic                          a_full,
    output logic [WIN_W-1:0]              a_fill,
    output logic [WIN_W-1:0]              a_win,
    output logic [SX_W-1:0]               a_sx,
    output logic [SUM_W-1:0]              a_sum,
    output logic [SXY_W-1:0]              a_wsum
);
    import tsb_pkg::*;

    localparam int WIN_RESET = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;
    localparam int PROD_W    = WIN_W + PRICE_BITS;

    logic [PRICE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [PRICE_BITS-1:0] rd_reg;
    logic [PRICE_BITS-1:0] byp_price_reg;
    logic                  byp_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [WIN_W-1:0] fill_reg;
    logic [WIN_W-1:0] win_reg;
    logic [SX_W-1:0]  sx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SXY_W-1:0] wsum_reg;

    logic                  a_valid_reg;
    logic [PRICE_BITS-1:0] a_price_reg;
    logic                  a_last_reg;
    logic                  a_full_reg;
    logic [WIN_W-1:0]      a_fill_reg;
    logic [WIN_W-1:0]      a_win_reg;
    logic [SX_W-1:0]       a_sx_reg;
    logic [SUM_W-1:0]      a_sum_reg;
    logic [SXY_W-1:0]      a_wsum_reg;

    logic                  accept;
    logic                  full;
    logic [PRICE_BITS-1:0] oldest;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;
    logic [PTR_W-1:0]      tail_next;
    logic [WIN_W-1:0]      fill_next;
    logic [SX_W-1:0]       sx_next;
    logic [SUM_W-1:0]      sum_next;
    logic [SXY_W-1:0]      wsum_next;
    logic [PROD_W-1:0]     new_term;
    logic [WIN_W-1:0]      win_clamped;

    assign in_ready = !a_valid_reg || a_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (fill_reg == win_reg);
    assign oldest   = byp_reg ? byp_price_reg : rd_reg;

    assign head_inc  = (head_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_next = full ? tail_inc : tail_reg;

    // on eviction every held entry moves down one position
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;
    assign sx_next   = full ? sx_reg : sx_reg + SX_W'(fill_next);
    assign new_term  = PROD_W'(fill_next) * PROD_W'(in_price);
    assign sum_next  = sum_reg + SUM_W'(in_price) - (full ? SUM_W'(oldest) : '0);
    assign wsum_next = (full ? wsum_reg - SXY_W'(sum_reg) : wsum_reg) + SXY_W'(new_term);

    always_comb
    begin
        priority if (win_value == '0)
        begin
            win_clamped = WIN_W'(1);
        end
        else if (int'(win_value) > WINDOW_MAX)
        begin
            win_clamped = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_clamped = WIN_W'(win_value);
        end
    end

    // ring storage, next oldest entry is fetched as each word goes in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[head_reg] <= in_price;
            rd_reg             <= ring_mem[tail_next];
            byp_price_reg      <= in_price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            win_reg     <= WIN_W'(WIN_RESET);
            sx_reg      <= '0;
            sum_reg     <= '0;
            wsum_reg    <= '0;
            byp_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (win_load)
            begin
                head_reg <= '0;
                tail_reg <= '0;
                fill_reg <= '0;
                win_reg  <= win_clamped;
                sx_reg   <= '0;
                sum_reg  <= '0;
                wsum_reg <= '0;
            end
            else if (accept)
            begin
                head_reg <= head_inc;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
                sx_reg   <= sx_next;
                sum_reg  <= sum_next;
                wsum_reg <= wsum_next;
                byp_reg  <= (tail_next == head_reg);
            end

            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_ready)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_price_reg <= in_price;
            a_last_reg  <= in_last;
            a_full_reg  <= (fill_next == win_reg);
            a_fill_reg  <= fill_next;
            a_win_reg   <= win_reg;
            a_sx_reg    <= sx_next;
            a_sum_reg   <= sum_next;
            a_wsum_reg  <= wsum_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_price = a_price_reg;
    assign a_last  = a_last_reg;
    assign a_full  = a_full_reg;
    assign a_fill  = a_fill_reg;
    assign a_win   = a_win_reg;
    assign a_sx    = a_sx_reg;
    assign a_sum   = a_sum_reg;
    assign a_wsum  = a_wsum_reg;

endmodule

`default_nettype wire

// ===== design/tsb_slope.sv =====
// slope numerator and trend signal, two register stages
`default_nettype none

module tsb_slope #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24,
    localparam int WIN_W = $clog2(WINDOW_MAX + 1),
    localparam int SX_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2,
    localparam int SX_W = $clog2(SX_MAX + 1),
    localparam int SUM_W = PRICE_BITS + WIN_W,
    localparam int SXY_W = PRICE_BITS + SX_W
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       a_valid,
    output logic                                       a_ready,
    input  logic [PRICE_BITS-1:0]                      a_price,
    input  logic                                       a_last,
    input  logic                                       a_full,
    input  logic [WIN_W-1:0]                           a_fill,
    input  logic [WIN_W-1:0]                           a_win,
    input  logic [SX_W-1:0]                            a_sx,
    input  logic [SUM_W-1:0]                           a_sum,
    input  logic [SXY_W-1:0]                           a_wsum,
    output logic                                       c_valid,
    input  logic                                       c_ready,
    output logic [PRICE_BITS-1:0]                      c_price,
    output logic                                       c_last,
    output tsb_pkg::signal_t                           c_signal,
    output logic [tsb_pkg::WINDOW_TOTAL_W-1:0]         c_total,
    output logic signed [tsb_pkg::SLOPE_W-1:0]         c_slope
);
    import tsb_pkg::*;

    localparam int P1_W  = WIN_W + SXY_W;
    localparam int P2_W  = SX_W + SUM_W;
    localparam int NUM_W = ((P1_W > P2_W) ? P1_W : P2_W) + 1;

    logic                  b_valid_reg;
    logic [PRICE_BITS-1:0] b_price_reg;
    logic                  b_last_reg;
    logic                  b_full_reg;
    logic [SUM_W-1:0]      b_sum_reg;
    logic [P1_W-1:0]       b_p1_reg;
    logic [P2_W-1:0]       b_p2_reg;
    logic                  b_gt_reg;
    logic                  b_lt_reg;

    logic                              c_valid_reg;
    logic [PRICE_BITS-1:0]             c_price_reg;
    logic                              c_last_reg;
    signal_t                           c_signal_reg;
    logic [WINDOW_TOTAL_W-1:0]         c_total_reg;
    logic signed [SLOPE_W-1:0]         c_slope_reg;

    logic              b_move;
    logic              a_move;
    logic [SUM_W-1:0]  scaled_price;
    logic signed [NUM_W-1:0] num;
    signal_t           sig;

    assign b_move  = b_valid_reg && (!c_valid_reg || c_ready);
    assign a_ready = !b_valid_reg || b_move;
    assign a_move  = a_valid && a_ready;

    // price times window against the window sum compares price with the average
    assign scaled_price = SUM_W'(a_price) * SUM_W'(a_win);

    assign num = $signed(NUM_W'(b_p1_reg)) - $signed(NUM_W'(b_p2_reg));

    always_comb
    begin
        priority if (b_full_reg && b_gt_reg && (num > 0))
        begin
            sig = SIG_BUY;
        end
        else if (b_full_reg && b_lt_reg && (num < 0))
        begin
            sig = SIG_SELL;
        end
        else
        begin
            sig = SIG_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_move)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_ready)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_price_reg <= a_price;
            b_last_reg  <= a_last;
            b_full_reg  <= a_full;
            b_sum_reg   <= a_sum;
            b_p1_reg    <= P1_W'(a_fill) * P1_W'(a_wsum);
            b_p2_reg    <= P2_W'(a_sx) * P2_W'(a_sum);
            b_gt_reg    <= (scaled_price > a_sum);
            b_lt_reg    <= (scaled_price < a_sum);
        end
        if (b_move)
        begin
            c_price_reg  <= b_price_reg;
            c_last_reg   <= b_last_reg;
            c_signal_reg <= sig;
            c_total_reg  <= WINDOW_TOTAL_W'(b_sum_reg);
            c_slope_reg  <= SLOPE_W'(num);
        end
    end

    assign c_valid  = c_valid_reg;
    assign c_price  = c_price_reg;
    assign c_last   = c_last_reg;
    assign c_signal = c_signal_reg;
    assign c_total  = c_total_reg;
    assign c_slope  = c_slope_reg;

endmodule

`default_nettype wire

// ===== design/tsb_trade.sv =====
// position and account bookkeeping with the output register
`default_nettype none

module tsb_trade #(
    parameter int PRICE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                bal_load,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]      bal_value,
    input  logic                                c_valid,
    output logic                                c_ready,
    input  logic [PRICE_BITS-1:0]               c_price,
    input  logic                                c_last,
    input  tsb_pkg::signal_t                    c_signal,
    input  logic [tsb_pkg::WINDOW_TOTAL_W-1:0]  c_total,
    input  logic signed [tsb_pkg::SLOPE_W-1:0]  c_slope,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tsb_pkg::result_t                    out_result,
    output logic                                out_last
);
    import tsb_pkg::*;

    localparam int PL_W = PRICE_BITS + 1;

    logic                        inpos_reg;
    logic [PRICE_BITS-1:0]       entry_reg;
    logic signed [BALANCE_W-1:0] bal_reg;
    logic [COUNT_W-1:0]          trades_reg;
    logic [COUNT_W-1:0]          wins_reg;
    logic [COUNT_W-1:0]          losses_reg;
    logic [PROFIT_W-1:0]         profit_reg;
    logic signed [LOSS_W-1:0]    loss_reg;
    logic                        second_reg;
    logic                        out_valid_reg;
    result_t                     out_reg;
    logic                        out_last_reg;

    logic                        emit;
    logic                        do_open;
    logic                        do_close;
    logic                        last_res;
    action_t                     action;
    logic signed [PL_W-1:0]      pl;
    logic                        pl_pos;
    logic signed [SAT_W-1:0]     bal_sum;
    logic signed [SAT_W-1:0]     profit_sum;
    logic signed [SAT_W-1:0]     loss_sum;
    logic signed [BALANCE_W-1:0] bal_next;
    logic [COUNT_W-1:0]          trades_next;
    logic [COUNT_W-1:0]          wins_next;
    logic [COUNT_W-1:0]          losses_next;
    logic [PROFIT_W-1:0]         profit_next;
    logic signed [LOSS_W-1:0]    loss_next;

    assign emit = c_valid && (!out_valid_reg || out_ready);

    // second pass of an item is the forced close after an open on the end word
    always_comb
    begin
        do_open  = 1'b0;
        do_close = 1'b0;
        action   = ACT_NONE;
        priority if (second_reg)
        begin
            do_close = 1'b1;
            action   = ACT_FINAL;
        end
        else if ((c_signal == SIG_BUY) && !inpos_reg)
        begin
            do_open = 1'b1;
            action  = ACT_OPEN;
        end
        else if ((c_signal == SIG_SELL) && inpos_reg)
        begin
            do_close = 1'b1;
            action   = ACT_CLOSE;
        end
        else if (c_last && inpos_reg)
        begin
            do_close = 1'b1;
            action   = ACT_FINAL;
        end
        else
        begin
            action = ACT_NONE;
        end
    end

    assign last_res = !(do_open && c_last);
    assign c_ready  = emit && last_res;

    assign pl     = $signed(PL_W'(c_price)) - $signed(PL_W'(entry_reg));
    assign pl_pos = (pl > 0);

    assign bal_sum    = SAT_W'(bal_reg) + SAT_W'(pl);
    assign profit_sum = $signed({2'b00, profit_reg}) + SAT_W'(pl);
    assign loss_sum   = SAT_W'(loss_reg) + SAT_W'(pl);

    always_comb
    begin
        bal_next    = bal_reg;
        trades_next = trades_reg;
        wins_next   = wins_reg;
        losses_next = losses_reg;
        profit_next = profit_reg;
        loss_next   = loss_reg;
        if (do_close)
        begin
            trades_next = (trades_reg == '1) ? trades_reg : trades_reg + 1'b1;
            if (pl_pos)
            begin
                wins_next   = (wins_reg == '1) ? wins_reg : wins_reg + 1'b1;
                profit_next = (profit_sum > SAT_HI) ? PROFIT_W'(SAT_HI)
                                                    : PROFIT_W'(profit_sum);
            end
            else
            begin
                losses_next = (losses_reg == '1) ? losses_reg : losses_reg + 1'b1;
                loss_next   = (loss_sum < SAT_LO) ? LOSS_W'(SAT_LO) : LOSS_W'(loss_sum);
            end
            priority if (bal_sum > SAT_HI)
            begin
                bal_next = BALANCE_W'(SAT_HI);
            end
            else if (bal_sum < SAT_LO)
            begin
                bal_next = BALANCE_W'(SAT_LO);
            end
            else
            begin
                bal_next = BALANCE_W'(bal_sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inpos_reg     <= 1'b0;
            entry_reg     <= '0;
            bal_reg       <= BALANCE_RESET;
            trades_reg    <= '0;
            wins_reg      <= '0;
            losses_reg    <= '0;
            profit_reg    <= '0;
            loss_reg      <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (bal_load)
            begin
                bal_reg <= BALANCE_W'(bal_value);
            end
            else if (emit)
            begin
                bal_reg <= bal_next;
            end

            if (emit)
            begin
                if (do_open)
                begin
                    inpos_reg <= 1'b1;
                    entry_reg <= c_price;
                end
                else if (do_close)
                begin
                    inpos_reg <= 1'b0;
                end
                trades_reg    <= trades_next;
                wins_reg      <= wins_next;
                losses_reg    <= losses_next;
                profit_reg    <= profit_next;
                loss_reg      <= loss_next;
                second_reg    <= !last_res;
                out_valid_reg <= 1'b1;
                out_last_reg  <= last_res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.trade_signal    <= c_signal;
            out_reg.trade_action    <= action;
            out_reg.trade_result    <= do_close ? TRADE_RESULT_W'(pl) : '0;
            out_reg.window_total    <= c_total;
            out_reg.slope_numerator <= c_slope;
            out_reg.balance_now     <= bal_next;
            out_reg.trades_done     <= trades_next;
            out_reg.wins_done       <= wins_next;
            out_reg.losses_done     <= losses_next;
            out_reg.profit_sum      <= profit_next;
            out_reg.loss_sum        <= loss_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// ===== design/trend_signal_backtester.sv =====
// top level of the trend signal backtester
//
// slave stream: one word per price sample, price in hundredths in the low bits of
// s_tdata, s_tlast marks the final sample of a series (an open position closes there)
// master stream: one result word per sample, two when a buy opens on the final
// sample (the open, then the forced close at the same price); m_tlast marks the last
// result word caused by a sample
// config port: cfg_we with cfg_index 0 writes the window length (clears the window,
// keeps position and account), index 1 writes the starting balance and loads it
// into the account; write only while the stream is idle
// latency: three cycles from the edge that accepts a sample to the edge that loads
// its first result word into the output register (four register stages: window
// update at the accepting edge, products, slope and signal, bookkeeping)
// throughput: one sample per cycle, set by the single-cycle window sum update; a
// sample that gives two results holds the bookkeeping stage for one extra cycle
// reset: empty window, window length 5, flat position, balance 1000000, counts zero
// when m_tready is low the pipeline stages fill and then s_tready drops; nothing is lost
`default_nettype none

module trend_signal_backtester #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // price sample stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((PRICE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // price
    input  logic                                    s_tlast,   // end of series
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // trade_signal, trade_action, trade_result, window_total, slope_numerator,
    // balance_now, trades_done, wins_done, losses_done, profit_sum, loss_sum, zero pad
    output logic [tsb_pkg::RESULT_DATA_W-1:0]       m_tdata,
    output logic                                    m_tlast,   // last result of a sample
    // configuration writes
    input  logic                                    cfg_we,
    input  logic [tsb_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import tsb_pkg::*;

    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SX_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
    localparam int SX_W   = $clog2(SX_MAX + 1);
    localparam int SUM_W  = PRICE_BITS + WIN_W;
    localparam int SXY_W  = PRICE_BITS + SX_W;

    // config decode
    logic win_load;
    logic bal_load;

    assign win_load = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
    assign bal_load = cfg_we && (cfg_index == REG_INITIAL_BALANCE);

    // window stage outputs
    logic                  a_valid;
    logic                  a_ready;
    logic [PRICE_BITS-1:0] a_price;
    logic                  a_last;
    logic                  a_full;
    logic [WIN_W-1:0]      a_fill;
    logic [WIN_W-1:0]      a_win;
    logic [SX_W-1:0]       a_sx;
    logic [SUM_W-1:0]      a_sum;
    logic [SXY_W-1:0]      a_wsum;

    // slope stage outputs
    logic                        c_valid;
    logic                        c_ready;
    logic [PRICE_BITS-1:0]       c_price;
    logic                        c_last;
    signal_t                     c_signal;
    logic [WINDOW_TOTAL_W-1:0]   c_total;
    logic signed [SLOPE_W-1:0]   c_slope;

    result_t res;

    tsb_window #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_load  (win_load),
        .win_value (cfg_data[WINLEN_W-1:0]),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_price  (s_tdata[PRICE_BITS-1:0]),
        .in_last   (s_tlast),
        .a_valid   (a_valid),
        .a_ready   (a_ready),
        .a_price   (a_price),
        .a_last    (a_last),
        .a_full    (a_full),
        .a_fill    (a_fill),
        .a_win     (a_win),
        .a_sx      (a_sx),
        .a_sum     (a_sum),
        .a_wsum    (a_wsum)
    );

    tsb_slope #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_slope (
        .clk      (clk),
        .rst_n    (rst_n),
        .a_valid  (a_valid),
        .a_ready  (a_ready),
        .a_price  (a_price),
        .a_last   (a_last),
        .a_full   (a_full),
        .a_fill   (a_fill),
        .a_win    (a_win),
        .a_sx     (a_sx),
        .a_sum    (a_sum),
        .a_wsum   (a_wsum),
        .c_valid  (c_valid),
        .c_ready  (c_ready),
        .c_price  (c_price),
        .c_last   (c_last),
        .c_signal (c_signal),
        .c_total  (c_total),
        .c_slope  (c_slope)
    );

    tsb_trade #(
        .PRICE_BITS (PRICE_BITS)
    ) u_trade (
        .clk        (clk),
        .rst_n      (rst_n),
        .bal_load   (bal_load),
        .bal_value  (cfg_data),
        .c_valid    (c_valid),
        .c_ready    (c_ready),
        .c_price    (c_price),
        .c_last     (c_last),
        .c_signal   (c_signal),
        .c_total    (c_total),
        .c_slope    (c_slope),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .out_last   (m_tlast)
    );

    // first field in the lowest bits
    assign m_tdata = {
        {RESULT_PAD_W{1'b0}},
        res.loss_sum,
        res.profit_sum,
        res.losses_done,
        res.wins_done,
        res.trades_done,
        res.balance_now,
        res.slope_numerator,
        res.window_total,
        res.trade_result,
        res.trade_action,
        res.trade_signal
    };

endmodule

`default_nettype wire
